/* sv/bbe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_pkg
// shared types and codes for the byte budget oldest first evictor
// ----------------------------------------------------------------------------
package bbe_pkg;

    localparam int ENTRIES = 16;

    // request kinds
    localparam logic [2:0] KIND_STORE    = 3'd0;
    localparam logic [2:0] KIND_RETRIEVE = 3'd1;
    localparam logic [2:0] KIND_DELETE   = 3'd2;
    localparam logic [2:0] KIND_CLEAR    = 3'd3;
    localparam logic [2:0] KIND_RESIZE   = 3'd4;

    // result status codes
    localparam logic [2:0] ST_STORED    = 3'd0;
    localparam logic [2:0] ST_REJECTED  = 3'd1;
    localparam logic [2:0] ST_DELETED   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FOUND     = 3'd4;
    localparam logic [2:0] ST_EVICTED   = 3'd5;
    localparam logic [2:0] ST_CLEARED   = 3'd6;
    localparam logic [2:0] ST_RESIZED   = 3'd7;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] key;
        logic [31:0] byte_count;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] result_key;
        logic [31:0] result_size;
        logic [31:0] used_bytes;
        logic        last;
    } t_out;

    typedef struct packed {
        logic        valid;
        logic [31:0] key;
        logic [31:0] size;
    } t_slot;

    // commands broadcast to every cell
    typedef struct packed {
        logic drop_hit;
        logic append;
        logic clear;
    } t_cell_ctl;

endpackage

/* sv/bbe_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_cell
// one table slot: holds key and size, matches a key, shifts toward the head
// ----------------------------------------------------------------------------
module bbe_cell
    import bbe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cell_ctl   i_ctl,
    input  logic [31:0] i_key,
    input  logic [31:0] i_size,
    input  logic        i_up_drop,
    input  logic        i_prev_valid,
    input  t_slot       i_next,
    output t_slot       o_slot,
    output logic        o_hit,
    output logic        o_down_drop
);

    logic        r_valid;
    logic [31:0] r_key;
    logic [31:0] r_size;
    logic        w_drop;
    logic        w_fill;

    assign o_hit       = r_valid && (r_key == i_key);
    assign w_drop      = i_up_drop || (i_ctl.drop_hit && o_hit);
    assign o_down_drop = w_drop;
    // first free slot takes the appended entry
    assign w_fill      = i_ctl.append && !r_valid && i_prev_valid;
    assign o_slot      = '{valid: r_valid, key: r_key, size: r_size};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.clear) begin
            r_valid <= 1'b0;
        end else if (w_drop) begin
            r_valid <= i_next.valid;
        end else if (w_fill) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_drop) begin
            r_key  <= i_next.key;
            r_size <= i_next.size;
        end else if (w_fill) begin
            r_key  <= i_key;
            r_size <= i_size;
        end
    end

endmodule

/* sv/byte_budget_oldest_first_evictor_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_budget_oldest_first_evictor_unit
// keyed table with byte sizes held in age order under a byte capacity,
// evicting the oldest entries to make room
// ----------------------------------------------------------------------------
//
//  beat    | dir | handshake               | payload
//  --------+-----+-------------------------+----------------------------------
//  request | in  | i_in_valid / o_in_ready | i_in  (kind, key, byte_count)
//  result  | out | o_out_valid/ i_out_ready| o_out (status, keys, sizes, last)
//
//  one request at a time: the beat is taken in idle, then the key lookup
//  in the cell row, then for store and resize one eviction per step
//  plus the final result; retrieve, delete, clear and a rejected store
//  end after the lookup, an unused kind code ends when it is taken
//  each result needs a free output register, a stalled result stops the
//  sequencer; a new request is taken while the last result still waits
//  synchronous active low reset empties the row, total and capacity at once
//
module byte_budget_oldest_first_evictor_unit
    import bbe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_OP    = 3'b010,
        S_EVICT = 3'b100
    } t_state;

    t_state      r_state, n_state;
    t_in         r_req;
    logic [31:0] r_total, n_total;
    logic [31:0] r_cap, n_cap;
    logic        r_out_valid, n_out_valid;
    t_out        r_out, n_out;

    // cell row wiring
    t_cell_ctl           w_ctl;
    logic                w_seed;
    t_slot               w_slot [ENTRIES];
    logic [ENTRIES-1:0]  w_hit;
    logic [ENTRIES-1:0]  w_valid;
    logic [ENTRIES:0]    w_drop_chain;

    logic                w_any_hit;
    logic [31:0]         w_hit_size;
    logic                w_can_emit;
    logic                w_too_big;
    logic                w_need_evict;
    logic [32:0]         w_sum;
    logic [31:0]         w_after_evict;

    assign w_drop_chain[0] = w_seed;   // seed drops everything: oldest out

    for (genvar j = 0; j < ENTRIES; j++) begin : g_cell
        logic  w_prev_valid;
        t_slot w_next;
        if (j == 0) begin : g_head
            assign w_prev_valid = 1'b1;
        end else begin : g_body
            assign w_prev_valid = w_slot[j-1].valid;
        end
        if (j == ENTRIES - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_slot[j+1];
        end

        bbe_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_key        (r_req.key),
            .i_size       (r_req.byte_count),
            .i_up_drop    (w_drop_chain[j]),
            .i_prev_valid (w_prev_valid),
            .i_next       (w_next),
            .o_slot       (w_slot[j]),
            .o_hit        (w_hit[j]),
            .o_down_drop  (w_drop_chain[j+1])
        );

        assign w_valid[j] = w_slot[j].valid;
    end

    // keys are unique in the row, so an or of masked sizes picks the hit
    always_comb begin
        w_hit_size = '0;
        for (int j = 0; j < ENTRIES; j++) begin
            w_hit_size = w_hit_size | (w_hit[j] ? w_slot[j].size : 32'd0);
        end
    end

    assign w_any_hit     = |w_hit;
    assign w_can_emit    = !r_out_valid || i_out_ready;
    assign w_too_big     = r_req.byte_count > r_cap;
    assign w_sum         = {1'b0, r_total} + {1'b0, r_req.byte_count};
    assign w_after_evict = r_total - w_slot[0].size;

    // store: evict while over budget or the row is full; resize: while over
    always_comb begin
        if (r_req.kind == KIND_STORE) begin
            w_need_evict = w_valid[0] &&
                           ((w_sum > {1'b0, r_cap}) || w_valid[ENTRIES-1]);
        end else begin
            w_need_evict = w_valid[0] && (r_total > r_req.byte_count);
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_state     = r_state;
        n_total     = r_total;
        n_cap       = r_cap;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        w_ctl       = '0;
        w_seed      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                // unused kind codes are taken and give no result
                if (i_in_valid && (i_in.kind <= KIND_RESIZE)) begin
                    n_state = S_OP;
                end
            end

            S_OP: begin
                case (r_req.kind)
                    KIND_STORE: begin
                        if (w_too_big) begin
                            if (w_can_emit) begin
                                n_out_valid = 1'b1;
                                n_out = '{ST_REJECTED, r_req.key, r_req.byte_count,
                                          r_total, 1'b1};
                                n_state = S_IDLE;
                            end
                        end else begin
                            // silently drop an older copy of the same key
                            w_ctl.drop_hit = 1'b1;
                            n_total = r_total - (w_any_hit ? w_hit_size : 32'd0);
                            n_state = S_EVICT;
                        end
                    end
                    KIND_RETRIEVE: begin
                        if (w_can_emit) begin
                            n_out_valid = 1'b1;
                            n_out = '{w_any_hit ? ST_FOUND : ST_NOT_FOUND, r_req.key,
                                      w_any_hit ? w_hit_size : 32'd0, r_total, 1'b1};
                            n_state = S_IDLE;
                        end
                    end
                    KIND_DELETE: begin
                        if (w_can_emit) begin
                            n_out_valid = 1'b1;
                            n_state     = S_IDLE;
                            if (w_any_hit) begin
                                w_ctl.drop_hit = 1'b1;
                                n_total = r_total - w_hit_size;
                                n_out = '{ST_DELETED, r_req.key, w_hit_size,
                                          r_total - w_hit_size, 1'b1};
                            end else begin
                                n_out = '{ST_NOT_FOUND, r_req.key, 32'd0, r_total, 1'b1};
                            end
                        end
                    end
                    KIND_CLEAR: begin
                        if (w_can_emit) begin
                            w_ctl.clear = 1'b1;
                            n_total     = '0;
                            n_out_valid = 1'b1;
                            n_out       = '{ST_CLEARED, 32'd0, 32'd0, 32'd0, 1'b1};
                            n_state     = S_IDLE;
                        end
                    end
                    KIND_RESIZE: begin
                        n_state = S_EVICT;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            S_EVICT: begin
                if (w_can_emit) begin
                    n_out_valid = 1'b1;
                    if (w_need_evict) begin
                        // oldest entry leaves, whole row shifts toward the head
                        w_seed  = 1'b1;
                        n_total = w_after_evict;
                        n_out   = '{ST_EVICTED, w_slot[0].key, w_slot[0].size,
                                    w_after_evict, 1'b0};
                    end else if (r_req.kind == KIND_STORE) begin
                        w_ctl.append = 1'b1;
                        n_total = w_sum[31:0];
                        n_out   = '{ST_STORED, r_req.key, r_req.byte_count,
                                    w_sum[31:0], 1'b1};
                        n_state = S_IDLE;
                    end else begin
                        n_cap   = r_req.byte_count;
                        n_out   = '{ST_RESIZED, 32'd0, 32'd0, r_total, 1'b1};
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_cap       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_cap       <= n_cap;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (i_in_valid && o_in_ready) begin
            r_req <= i_in;
        end
    end

    // occupied slots always form a prefix from the head
    a_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid >> 1) & ~w_valid) == '0)
        else $error("occupied slots not packed at the head");

    // a key is never held twice
    a_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_hit))
        else $error("key matches more than one slot");

    // held bytes never exceed the capacity
    a_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= r_cap)
        else $error("byte total above capacity");

    // an empty row holds no bytes
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_valid[0] |-> (r_total == 32'd0))
        else $error("empty table with nonzero byte total");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives store, retrieve, delete, clear and resize requests into the byte
// budget evictor and checks every result beat against a software copy of
// the age-ordered table, with random idling on both sides
// ----------------------------------------------------------------------------
module testbench
    import bbe_pkg::*;
();

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 12;
    localparam int QUIET_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 40;
    localparam int PHASE_ITEMS  = 55;
    localparam int KEY_POOL     = 28;

    logic i_clk     = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic out_ready = 1'b0;
    t_in  in_data   = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    logic [31:0] key_pool [KEY_POOL];

    // table of held entries in age order, slot 0 the oldest
    class byte_budget_table;
        logic [31:0] held_key  [ENTRIES];
        logic [31:0] held_size [ENTRIES];
        int          held;
        logic [31:0] used;
        logic [31:0] limit;
        t_out        due_results [$];
        int          mismatches;

        function new();
            held       = 0;
            used       = '0;
            limit      = '0;
            mismatches = 0;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function int find_key(logic [31:0] k);
            for (int i = 0; i < held; i++) begin
                if (held_key[i] == k) return i;
            end
            return -1;
        endfunction

        function void drop_at(int idx);
            used = used - held_size[idx];
            for (int j = idx; j + 1 < held; j++) begin
                held_key[j]  = held_key[j + 1];
                held_size[j] = held_size[j + 1];
            end
            held--;
        endfunction

        function void push_result(logic [2:0] st, logic [31:0] k, logic [31:0] s, logic fin);
            t_out r;
            r.status      = st;
            r.result_key  = k;
            r.result_size = s;
            r.used_bytes  = used;
            r.last        = fin;
            due_results.insert(due_results.size(), r);
        endfunction

        function void evict_oldest();
            logic [31:0] k;
            logic [31:0] s;
            k = held_key[0];
            s = held_size[0];
            drop_at(0);
            push_result(ST_EVICTED, k, s, 1'b0);
        endfunction

        function void apply_request(t_in req);
            int          idx;
            logic [32:0] need;
            case (req.kind)
                KIND_STORE: begin
                    if (req.byte_count > limit) begin
                        push_result(ST_REJECTED, req.key, req.byte_count, 1'b1);
                    end else begin
                        // same key goes away silently before any eviction
                        idx = find_key(req.key);
                        if (idx >= 0) drop_at(idx);
                        need = {1'b0, used} + {1'b0, req.byte_count};
                        while (held > 0 && (need > {1'b0, limit} || held >= ENTRIES)) begin
                            evict_oldest();
                            need = {1'b0, used} + {1'b0, req.byte_count};
                        end
                        held_key[held]  = req.key;
                        held_size[held] = req.byte_count;
                        held++;
                        used = used + req.byte_count;
                        push_result(ST_STORED, req.key, req.byte_count, 1'b1);
                    end
                end
                KIND_RETRIEVE: begin
                    idx = find_key(req.key);
                    if (idx < 0) push_result(ST_NOT_FOUND, req.key, '0, 1'b1);
                    else push_result(ST_FOUND, req.key, held_size[idx], 1'b1);
                end
                KIND_DELETE: begin
                    idx = find_key(req.key);
                    if (idx < 0) begin
                        push_result(ST_NOT_FOUND, req.key, '0, 1'b1);
                    end else begin
                        need = {1'b0, held_size[idx]};
                        drop_at(idx);
                        push_result(ST_DELETED, req.key, need[31:0], 1'b1);
                    end
                end
                KIND_CLEAR: begin
                    held = 0;
                    used = '0;
                    push_result(ST_CLEARED, '0, '0, 1'b1);
                end
                KIND_RESIZE: begin
                    while (held > 0 && used > req.byte_count) evict_oldest();
                    limit = req.byte_count;
                    push_result(ST_RESIZED, '0, '0, 1'b1);
                end
                default: begin
                    // unused kind codes give no result
                end
            endcase
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected %h, actual %h", field, want, got);
                mismatches++;
            end
        endfunction

        function void match_result(t_out got);
            t_out want;
            if (due_results.size() == 0) begin
                $error("result beat with nothing expected: status %0d key %h",
                       got.status, got.result_key);
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("result_key", want.result_key, got.result_key);
            compare_field("result_size", want.result_size, got.result_size);
            compare_field("used_bytes", want.used_bytes, got.used_bytes);
            compare_field("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    byte_budget_table table_model = new();

    byte_budget_oldest_first_evictor_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // result side: random stall, check every accepted beat
    always @(posedge i_clk) begin
        if (rst_n && o_out_valid && out_ready) table_model.match_result(o_out);
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // no beat on either side for too long ends the run
    always @(posedge i_clk) begin
        if (!rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // valid stays high after a beat; every pause lowers it first
    task automatic send_request(input t_in req);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        table_model.apply_request(req);
    endtask

    task automatic send_fields(input logic [2:0] kind, input logic [31:0] key,
                               input logic [31:0] bytes);
        t_in req;
        req.kind       = kind;
        req.key        = key;
        req.byte_count = bytes;
        send_request(req);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (table_model.pending() != 0);
    endtask

    function automatic logic [31:0] store_size(logic [31:0] lim);
        int pick;
        pick = $urandom_range(99);
        if (pick < 15) return $urandom_range(0, 3);
        if (pick < 70) return $urandom_range(0, lim / 6);
        if (pick < 75) return lim;
        if (pick < 85) begin
            // just over the limit, rejected
            if (lim < 32'hFFFF_FF00) return lim + $urandom_range(1, 200);
            return $urandom();
        end
        return $urandom();
    endfunction

    function automatic logic [31:0] new_limit();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40) return $urandom_range(0, 400);
        if (pick < 65) return $urandom_range(1000, 100000);
        if (pick < 80) return 32'hFFFF_FFFF;
        if (pick < 90) return '0;
        return $urandom();
    endfunction

    function automatic t_in random_request();
        t_in r;
        int  pick;
        pick = $urandom_range(99);
        r.key        = ($urandom_range(99) < 85) ? key_pool[$urandom_range(KEY_POOL - 1)]
                                                 : $urandom();
        r.byte_count = $urandom();
        if (pick < 3) begin
            r.kind = 3'($urandom_range(5, 7));
        end else if (pick < 55) begin
            r.kind       = KIND_STORE;
            r.byte_count = store_size(table_model.limit);
        end else if (pick < 70) begin
            r.kind = KIND_RETRIEVE;
        end else if (pick < 84) begin
            r.kind = KIND_DELETE;
        end else if (pick < 88) begin
            r.kind = KIND_CLEAR;
        end else begin
            r.kind       = KIND_RESIZE;
            r.byte_count = new_limit();
        end
        return r;
    endfunction

    initial begin
        t_in req;
        int  taken;
        for (int i = 0; i < KEY_POOL; i++) key_pool[i] = $urandom();
        key_pool[0] = '0;
        key_pool[1] = 32'hFFFF_FFFF;

        repeat (RESET_CYCLES) @(posedge i_clk);
        rst_n <= 1'b1;

        // directed part
        send_fields(KIND_RESIZE, $urandom(), 32'hFFFF_FFFF);
        // zero-size stores fill the table, the seventeenth evicts on slot count
        for (int i = 0; i < ENTRIES + 1; i++) begin
            send_fields(KIND_STORE, (i == ENTRIES) ? 32'hFFFF_FFFF : 32'(i), '0);
        end
        send_fields(KIND_STORE, 32'h8000_0000, 32'hFFFF_FFFF);
        // repeated key plus byte overflow: evicts everything left
        send_fields(KIND_STORE, 32'd5, 32'd1);
        send_fields(KIND_STORE, 32'd5, 32'd7);
        send_fields(KIND_RETRIEVE, 32'd5, $urandom());
        send_fields(KIND_RETRIEVE, 32'h0000_1234, $urandom());
        send_fields(KIND_DELETE, 32'd5, $urandom());
        send_fields(KIND_DELETE, 32'd5, $urandom());
        send_fields(KIND_STORE, 32'd9, 32'd20);
        send_fields(KIND_STORE, 32'd10, 32'd30);
        send_fields(KIND_RESIZE, $urandom(), 32'd25);
        send_fields(KIND_STORE, 32'd11, 32'd26);
        send_fields(KIND_STORE, 32'd12, 32'd25);
        send_fields(KIND_RESIZE, $urandom(), '0);
        send_fields(KIND_STORE, 32'd13, '0);
        send_fields(KIND_STORE, 32'd14, 32'd1);
        send_fields(3'd5, $urandom(), $urandom());
        send_fields(3'd6, $urandom(), $urandom());
        send_fields(3'd7, $urandom(), $urandom());
        send_fields(KIND_CLEAR, $urandom(), $urandom());
        wait_for_results();

        // random part, one idling pattern per phase
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 78;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 78;
                end
                default: begin
                    send_idle_pct  = 12;
                    recv_stall_pct = 12;
                end
            endcase
            taken = 0;
            while (taken < PHASE_ITEMS) begin
                if ($urandom_range(99) < 2) wait_for_results();
                req = random_request();
                send_request(req);
                if (req.kind <= KIND_RESIZE) taken++;
            end
            wait_for_results();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (table_model.mismatches == 0 && table_model.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
